@@ sv/sbts_pkg.sv @@
// sbts_pkg: shared types, codes and helpers for the bus transaction sequencer
// holds the beat structs, phase/failure/mode codes and the checksum fold
// no dependencies
package sbts_pkg;

  localparam int unsigned READ_BUFFER_WORDS = 258;
  localparam int unsigned COUNT_W = 9;

  localparam logic [31:0] IWT_RESET = 32'd300;
  localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [COUNT_W-1:0] BUFFER_WORDS = COUNT_W'(READ_BUFFER_WORDS);

  // item modes
  localparam logic [2:0] MODE_START_WRITE = 3'd0;
  localparam logic [2:0] MODE_START_READ  = 3'd1;
  localparam logic [2:0] MODE_WRITE_DONE  = 3'd2;
  localparam logic [2:0] MODE_FRAME_EDGE  = 3'd3;
  localparam logic [2:0] MODE_RX_WORD     = 3'd4;
  localparam logic [2:0] MODE_POLL        = 3'd5;

  // transaction phases
  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_WRITING      = 3'd1;
  localparam logic [2:0] PH_WRITE_DONE   = 3'd2;
  localparam logic [2:0] PH_WRITE_FAILED = 3'd3;
  localparam logic [2:0] PH_AWAIT_READ   = 3'd4;
  localparam logic [2:0] PH_READING      = 3'd5;
  localparam logic [2:0] PH_READ_DONE    = 3'd6;
  localparam logic [2:0] PH_READ_FAILED  = 3'd7;

  // failure codes
  localparam logic [2:0] FAIL_NONE     = 3'd0;
  localparam logic [2:0] FAIL_CHECKSUM = 3'd1;
  localparam logic [2:0] FAIL_MISSING  = 3'd2;
  localparam logic [2:0] FAIL_OVERFLOW = 3'd3;
  localparam logic [2:0] FAIL_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] now_us;
    logic        expect_response;
    logic [31:0] timeout_us;
    logic        wait_forever;
    logic [31:0] write_time_us;
    logic        lines_idle;
    logic [31:0] data_word;
  } sbts_in_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         phase;
    logic [2:0]         failure;
    logic [COUNT_W-1:0] read_length;
  } sbts_out_t;

  // xor of the four bytes of a word
  function automatic logic [7:0] fold_bytes(input logic [31:0] w);
    fold_bytes = w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
  endfunction

endpackage

@@ sv/sbts_core.sv @@
// sbts_core: phase state, deadline tracking and received-word bookkeeping
// processes one registered beat per step and produces its result
// depends on sbts_pkg
module sbts_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  sbts_pkg::sbts_in_t  item,
  input  logic [31:0]       inter_word_timeout_us,
  output sbts_pkg::sbts_out_t result
);
  import sbts_pkg::*;

  logic [2:0]         cur_phase, cur_phase_next;
  logic               await_response, await_response_next;
  logic [31:0]        response_timeout, response_timeout_next;
  logic               response_forever, response_forever_next;
  logic [63:0]        deadline_us, deadline_us_next;
  logic [63:0]        last_word_time_us, last_word_time_us_next;
  logic [COUNT_W-1:0] words_received, words_received_next;
  logic [COUNT_W-1:0] words_at_last_poll, words_at_last_poll_next;
  logic [31:0]        first_word, first_word_next;
  logic [31:0]        last_word, last_word_next;
  logic [31:0]        word_xor, word_xor_next;

  logic [63:0]        elapsed;
  logic [63:0]        read_deadline;
  logic [63:0]        resp_deadline;
  logic               checksum_ok;
  logic               length_ok;

  // shared arithmetic
  assign elapsed       = item.now_us - last_word_time_us;
  assign read_deadline = item.wait_forever ? ALL_ONES64 : item.now_us + 64'(item.timeout_us);
  assign resp_deadline = response_forever ? ALL_ONES64
                                          : item.now_us + 64'(response_timeout);
  assign checksum_ok   = (last_word == {24'd0, fold_bytes(word_xor ^ last_word)});
  assign length_ok     = ({1'b0, first_word[7:0]} <= (words_received - COUNT_W'(2)));

  // next state and result for the current beat
  always_comb begin
    logic polled;
    logic [2:0] rep;
    polled                  = 1'b0;
    rep                     = cur_phase;
    cur_phase_next          = cur_phase;
    await_response_next     = await_response;
    response_timeout_next   = response_timeout;
    response_forever_next   = response_forever;
    deadline_us_next        = deadline_us;
    last_word_time_us_next  = last_word_time_us;
    words_received_next     = words_received;
    words_at_last_poll_next = words_at_last_poll;
    first_word_next         = first_word;
    last_word_next          = last_word;
    word_xor_next           = word_xor;
    result.accepted         = 1'b0;
    result.failure          = FAIL_NONE;
    result.read_length      = '0;

    unique case (item.mode)
      MODE_START_WRITE: begin
        if (cur_phase == PH_IDLE && item.lines_idle) begin
          await_response_next     = item.expect_response;
          response_timeout_next   = item.timeout_us;
          response_forever_next   = item.wait_forever;
          words_received_next     = '0;
          words_at_last_poll_next = '0;
          first_word_next         = '0;
          last_word_next          = '0;
          word_xor_next           = '0;
          deadline_us_next        = item.now_us + 64'(item.write_time_us);
          cur_phase_next          = PH_WRITING;
          result.accepted         = 1'b1;
        end
      end
      MODE_START_READ: begin
        if (cur_phase == PH_IDLE) begin
          words_received_next     = '0;
          words_at_last_poll_next = '0;
          first_word_next         = '0;
          last_word_next          = '0;
          word_xor_next           = '0;
          deadline_us_next        = read_deadline;
          cur_phase_next          = PH_AWAIT_READ;
          result.accepted         = 1'b1;
        end
      end
      MODE_WRITE_DONE: begin
        if (cur_phase == PH_WRITING) begin
          if (await_response) begin
            deadline_us_next = resp_deadline;
            cur_phase_next   = PH_AWAIT_READ;
          end else begin
            cur_phase_next = PH_WRITE_DONE;
          end
        end
      end
      MODE_FRAME_EDGE: begin
        if (cur_phase == PH_AWAIT_READ) begin
          cur_phase_next         = PH_READING;
          last_word_time_us_next = item.now_us;
        end else if (cur_phase == PH_READING) begin
          cur_phase_next = PH_READ_DONE;
        end
      end
      MODE_RX_WORD: begin
        if (cur_phase == PH_READING && words_received < BUFFER_WORDS) begin
          if (words_received == '0) begin
            first_word_next = item.data_word;
          end
          last_word_next      = item.data_word;
          word_xor_next       = word_xor ^ item.data_word;
          words_received_next = words_received + COUNT_W'(1);
        end
      end
      MODE_POLL: begin
        polled = 1'b1;
        if (cur_phase == PH_READ_DONE) begin
          // length and checksum check of the finished frame
          if (words_received > COUNT_W'(1) && length_ok) begin
            if (checksum_ok) begin
              result.read_length = words_received - COUNT_W'(1);
            end else begin
              rep            = PH_READ_FAILED;
              result.failure = FAIL_CHECKSUM;
            end
          end else begin
            rep            = PH_READ_FAILED;
            result.failure = FAIL_MISSING;
          end
          cur_phase_next = PH_IDLE;
        end else if (cur_phase == PH_WRITE_DONE) begin
          cur_phase_next = PH_IDLE;
        end else if (cur_phase == PH_READING) begin
          if (words_received >= BUFFER_WORDS) begin
            rep            = PH_READ_FAILED;
            result.failure = FAIL_OVERFLOW;
            cur_phase_next = PH_IDLE;
          end else if (words_at_last_poll == words_received) begin
            // inter-word gap check
            if (item.now_us > last_word_time_us &&
                elapsed >= 64'(inter_word_timeout_us)) begin
              rep            = PH_READ_FAILED;
              result.failure = FAIL_TIMEOUT;
              cur_phase_next = PH_IDLE;
            end
          end else begin
            words_at_last_poll_next = words_received;
            last_word_time_us_next  = item.now_us;
          end
        end else if (cur_phase != PH_IDLE && item.now_us >= deadline_us) begin
          rep            = (cur_phase == PH_AWAIT_READ) ? PH_READ_FAILED : PH_WRITE_FAILED;
          result.failure = FAIL_TIMEOUT;
          cur_phase_next = PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    result.phase = polled ? rep : cur_phase_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase          <= PH_IDLE;
      await_response     <= 1'b0;
      response_timeout   <= '0;
      response_forever   <= 1'b0;
      deadline_us        <= ALL_ONES64;
      last_word_time_us  <= '0;
      words_received     <= '0;
      words_at_last_poll <= '0;
      first_word         <= '0;
      last_word          <= '0;
      word_xor           <= '0;
    end else if (step) begin
      cur_phase          <= cur_phase_next;
      await_response     <= await_response_next;
      response_timeout   <= response_timeout_next;
      response_forever   <= response_forever_next;
      deadline_us        <= deadline_us_next;
      last_word_time_us  <= last_word_time_us_next;
      words_received     <= words_received_next;
      words_at_last_poll <= words_at_last_poll_next;
      first_word         <= first_word_next;
      last_word          <= last_word_next;
      word_xor           <= word_xor_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    words_received <= BUFFER_WORDS)
    else $error("word count beyond buffer size");

  a_poll_mark_bound: assert property (@(posedge clk) disable iff (rst)
    words_at_last_poll <= words_received)
    else $error("poll mark ahead of word count");

  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    step && result.accepted |=> (cur_phase == PH_WRITING || cur_phase == PH_AWAIT_READ))
    else $error("accepted start did not open a transaction");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(cur_phase) && $stable(words_received))
    else $error("state moved without a beat");
`endif

endmodule

@@ sv/serial_bus_transaction_sequencer_unit.sv @@
// Serial bus transaction sequencer: input register, sbts_core, result register; uses sbts_pkg.
// An accepted beat goes to the input register, then its result to the result register.
// Throughput: one beat per cycle unless out_ready stalls; core state updates once per beat.
// Reset (synchronous, rst high): phase idle, counters and words cleared,
// deadline all ones, inter-word timeout back to 300 us, both stages empty.
module serial_bus_transaction_sequencer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbts_pkg::sbts_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbts_pkg::sbts_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);
  import sbts_pkg::*;

  logic        in_held;
  sbts_in_t    in_q;
  logic        advance;
  logic        step;
  logic [31:0] inter_word_timeout_us;
  sbts_out_t   core_result;

  // stage handshake
  assign advance  = !out_valid || out_ready;
  assign step     = in_held && advance;
  assign in_ready = !in_held || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      inter_word_timeout_us <= IWT_RESET;
    end else if (cfg_wr_en) begin
      inter_word_timeout_us <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  sbts_core u_core (
    .clk                   (clk),
    .rst                   (rst),
    .step                  (step),
    .item                  (in_q),
    .inter_word_timeout_us (inter_word_timeout_us),
    .result                (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= core_result;
    end
  end

endmodule
